>>> sv/apdt_pkg.sv
`default_nettype none

package apdt_pkg;

  // Table size default
  localparam int SLOT_COUNT_DEFAULT = 16;

  // Field widths
  localparam int SLOT_W      = 4;
  localparam int PERIOD_W    = 17;
  localparam int TIME_W      = 32;
  localparam int OFFSET_W    = 17;
  localparam int EXT_W       = 34;  // signed offset time
  localparam int MAG_W       = 33;  // magnitude of the offset time
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 17;

  // Remainder unit: one quotient bit per cycle
  localparam int DIV_STEPS = MAG_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Unix time of 2018-01-01 00:00:00 UTC
  localparam logic [TIME_W-1:0] YEAR_2018_START = 32'd1514764800;

  // Opcodes
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_TIME_ENABLE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ZONE_OFFSET       = 1'd1;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic decide;
    logic div_step;
    logic fix;
    logic write;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic arm;
    logic div_last;
  } dp_status_t;

endpackage

`default_nettype wire

>>> sv/apdt_ram.sv
`default_nettype none

module apdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                         wr_data,
  input  wire logic                                     rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> sv/apdt_ctrl.sv
`default_nettype none

module apdt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output apdt_pkg::dp_cmd_t      cmd,
  input  wire apdt_pkg::dp_status_t status
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_DIV   = 6'b000100,
    S_FIX   = 6'b001000,
    S_WRITE = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  assign in_stall = (state != S_IDLE);

  // Sequencing
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_READ;
        end
      end
      S_READ: begin
        cmd.decide = 1'b1;
        state_next = status.arm ? S_DIV : S_DONE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_FIX;
        end
      end
      S_FIX: begin
        cmd.fix    = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.write  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output beat flag
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/apdt_dp.sv
`default_nettype none

module apdt_dp #(
  parameter int SLOT_COUNT = apdt_pkg::SLOT_COUNT_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write,
  input  wire logic [apdt_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [apdt_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire apdt_pkg::dp_cmd_t                    cmd,
  output apdt_pkg::dp_status_t                      status,
  input  wire logic                                 opcode,
  input  wire logic [apdt_pkg::SLOT_W-1:0]          slot,
  input  wire logic [apdt_pkg::PERIOD_W-1:0]        period_seconds,
  input  wire logic [apdt_pkg::TIME_W-1:0]          now_seconds,
  output logic                                      due,
  output logic      [apdt_pkg::TIME_W-1:0]          next_deadline
);

  localparam int ADDR_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int ENTRY_W = apdt_pkg::PERIOD_W + apdt_pkg::TIME_W;
  localparam int P_W     = apdt_pkg::PERIOD_W;
  localparam int T_W     = apdt_pkg::TIME_W;
  localparam int X_W     = apdt_pkg::EXT_W;
  localparam int M_W     = apdt_pkg::MAG_W;

  // Configuration
  logic                            local_time_enable;
  logic [apdt_pkg::OFFSET_W-1:0]   zone_offset;

  // Item registers
  logic              op_r;
  logic              in_range_r;
  logic [ADDR_W-1:0] addr_r;
  logic [P_W-1:0]    period_in_r;
  logic [T_W-1:0]    now_r;
  logic [X_W-1:0]    t_r;
  logic [P_W-1:0]    p_r;
  logic [X_W-1:0]    tp_r;
  logic              neg_r;
  logic              due_r;
  logic [T_W-1:0]    next_r;

  // Remainder unit
  logic [P_W-1:0]                 rem_r;
  logic [M_W-1:0]                 quo_r;
  logic [apdt_pkg::DIV_CNT_W-1:0] cnt_r;

  logic valid_r [SLOT_COUNT];

  // Capture side
  logic [ADDR_W+apdt_pkg::SLOT_W-1:0] slot_ext;
  logic [ADDR_W-1:0]                  slot_addr;
  logic                               in_range;
  logic [X_W-1:0]                     offset_ext;
  logic [X_W-1:0]                     t_in;

  // Decide side
  logic [ENTRY_W-1:0] rd_data;
  logic [P_W-1:0]     stored_p;
  logic [T_W-1:0]     stored_d;
  logic [P_W-1:0]     p_sel;
  logic               slot_set;
  logic [T_W-1:0]     window_start;
  logic               fire;
  logic               arm;
  logic [X_W-1:0]     t_neg;
  logic [M_W-1:0]     mag;
  logic [X_W-1:0]     tp;

  // Division step and fix-up
  logic [P_W:0]   trial;
  logic           trial_ge;
  logic [P_W-1:0] rem_floor;
  logic [X_W-1:0] deadline;

  assign slot_ext   = {{ADDR_W{1'b0}}, slot};
  assign slot_addr  = slot_ext[ADDR_W-1:0];
  assign in_range   = ({28'd0, slot} < 32'(SLOT_COUNT));
  assign offset_ext = local_time_enable ?
                      {{(X_W - apdt_pkg::OFFSET_W){zone_offset[apdt_pkg::OFFSET_W-1]}},
                       zone_offset} : '0;
  assign t_in       = {2'b00, now_seconds} + offset_ext;

  assign stored_p     = rd_data[ENTRY_W-1:T_W];
  assign stored_d     = rd_data[T_W-1:0];
  assign p_sel        = (op_r == apdt_pkg::OP_ADD) ? period_in_r : stored_p;
  assign slot_set     = in_range_r && valid_r[addr_r];
  assign window_start = stored_d - {{(T_W - P_W){1'b0}}, stored_p};
  assign fire         = (now_r >= apdt_pkg::YEAR_2018_START) &&
                        ((stored_d <= now_r) || (window_start > now_r));
  assign arm          = in_range_r &&
                        ((op_r == apdt_pkg::OP_ADD) || (slot_set && fire));
  assign t_neg        = -t_r;
  assign mag          = t_r[X_W-1] ? t_neg[M_W-1:0] : t_r[M_W-1:0];
  assign tp           = t_r + {{(X_W - P_W){1'b0}}, p_sel};

  assign trial    = {rem_r, quo_r[M_W-1]};
  assign trial_ge = (trial >= {1'b0, p_r});

  // Floored remainder: mirror a nonzero remainder for a negative time
  always_comb begin
    if (p_r == '0) begin
      rem_floor = '0;
    end else if (neg_r && (rem_r != '0)) begin
      rem_floor = p_r - rem_r;
    end else begin
      rem_floor = rem_r;
    end
  end

  assign deadline = tp_r - {{(X_W - P_W){1'b0}}, rem_floor};

  assign status.arm      = arm;
  assign status.div_last = (cnt_r == apdt_pkg::DIV_CNT_W'(apdt_pkg::DIV_STEPS - 1));

  // Period and deadline store
  apdt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.write),
    .wr_addr (addr_r),
    .wr_data ({p_r, next_r}),
    .rd_en   (cmd.capture),
    .rd_addr (slot_addr),
    .rd_data (rd_data)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      local_time_enable <= 1'b0;
      zone_offset       <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        apdt_pkg::CFG_LOCAL_TIME_ENABLE: local_time_enable <= cfg_data[0];
        apdt_pkg::CFG_ZONE_OFFSET:       zone_offset       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Slot valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else if (cmd.write) begin
      valid_r[addr_r] <= 1'b1;
    end
  end

  // Item datapath
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r        <= opcode;
      in_range_r  <= in_range;
      addr_r      <= slot_addr;
      period_in_r <= period_seconds;
      now_r       <= now_seconds;
      t_r         <= t_in;
    end
    if (cmd.decide) begin
      p_r    <= p_sel;
      tp_r   <= tp;
      neg_r  <= t_r[X_W-1];
      quo_r  <= mag;
      rem_r  <= '0;
      cnt_r  <= '0;
      due_r  <= arm;
      next_r <= (slot_set && (op_r == apdt_pkg::OP_CHECK)) ? stored_d : '0;
    end
    if (cmd.div_step) begin
      rem_r <= trial_ge ? P_W'(trial - {1'b0, p_r}) : trial[P_W-1:0];
      quo_r <= {quo_r[M_W-2:0], 1'b0};
      cnt_r <= cnt_r + apdt_pkg::DIV_CNT_W'(1);
    end
    if (cmd.fix) begin
      next_r <= deadline[T_W-1:0];
    end
    if (cmd.load_out) begin
      due           <= due_r;
      next_deadline <= next_r;
    end
  end

endmodule

`default_nettype wire

>>> sv/aligned_periodic_due_table_top.sv
// Channel  | Handshake              | Beat contents
// ---------+------------------------+------------------------------------------
// in       | in_valid / in_stall    | opcode, slot, period_seconds, now_seconds
// out      | out_valid / out_stall  | due, next_deadline
// cfg      | cfg_write              | cfg_index, cfg_data
//
// An item that re-arms a slot (an add to a slot in range, a check that fires) passes
// from accept to result through table read, 33 steps of the restoring remainder unit
// (one bit per cycle), fix-up, write-back and result. Other items skip from table read to result.
// Reset clears the slot valid bits and both registers at once; no sweep.
// The result register holds a beat under out_stall; the next item proceeds and then waits.
`default_nettype none

module aligned_periodic_due_table_top #(
  parameter int SLOT_COUNT = apdt_pkg::SLOT_COUNT_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [apdt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [apdt_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             opcode,
  input  wire logic [apdt_pkg::SLOT_W-1:0]      slot,
  input  wire logic [apdt_pkg::PERIOD_W-1:0]    period_seconds,
  input  wire logic [apdt_pkg::TIME_W-1:0]      now_seconds,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  due,
  output logic      [apdt_pkg::TIME_W-1:0]      next_deadline
);

  apdt_pkg::dp_cmd_t    cmd;
  apdt_pkg::dp_status_t status;

  apdt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  apdt_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .status         (status),
    .opcode         (opcode),
    .slot           (slot),
    .period_seconds (period_seconds),
    .now_seconds    (now_seconds),
    .due            (due),
    .next_deadline  (next_deadline)
  );

endmodule

`default_nettype wire

>>> tb/sv/tb_aligned_periodic_due_table_top.sv
`timescale 1ns / 1ps

module tb_aligned_periodic_due_table_top;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SLOTS       = 16;
  localparam int REPORT_MAX  = 40;

  // One answer beat: fired flag and the deadline left in the slot
  typedef struct packed {
    logic                        fired;
    logic [apdt_pkg::TIME_W-1:0] deadline;
  } answer_t;

  // Tracks the schedule table and the answers still owed by the block
  class due_table_tracker;
    logic [apdt_pkg::PERIOD_W-1:0]        period_of [SLOTS];
    logic [apdt_pkg::TIME_W-1:0]          deadline_of [SLOTS];
    bit                                   armed [SLOTS];
    bit                                   local_mode;
    logic signed [apdt_pkg::OFFSET_W-1:0] zone_shift;
    answer_t                              pending_answers [$];
    int                                   errors;

    function new();
      foreach (armed[i]) armed[i] = 1'b0;
      local_mode = 1'b0;
      zone_shift = '0;
      errors     = 0;
    endfunction

    function void write_register(logic [apdt_pkg::CFG_INDEX_W-1:0] index,
                                 logic [apdt_pkg::CFG_DATA_W-1:0] data);
      case (index)
        apdt_pkg::CFG_LOCAL_TIME_ENABLE: local_mode = data[0];
        apdt_pkg::CFG_ZONE_OFFSET:       zone_shift = data;
        default: ;
      endcase
    endfunction

    // Round now (plus the shift in local mode) down to a multiple of the period, add one period
    function logic [apdt_pkg::TIME_W-1:0] aligned_deadline(
        logic [apdt_pkg::TIME_W-1:0] now, logic [apdt_pkg::PERIOD_W-1:0] period);
      longint t;
      longint p;
      longint r;
      longint aligned;
      t = longint'(now);
      p = longint'(period);
      if (local_mode) t = t + longint'(zone_shift);
      if (p == 0) begin
        aligned = t;
      end else begin
        r = t % p;
        if (r < 0) r = r + p;  // floor toward minus infinity
        aligned = t - r;
      end
      return apdt_pkg::TIME_W'(aligned + p);
    endfunction

    function void note_request(logic op, logic [apdt_pkg::SLOT_W-1:0] s,
                               logic [apdt_pkg::PERIOD_W-1:0] period,
                               logic [apdt_pkg::TIME_W-1:0] now);
      answer_t                     a;
      logic [apdt_pkg::TIME_W-1:0] d;
      logic [apdt_pkg::TIME_W-1:0] prior;
      a = '0;
      if (op == apdt_pkg::OP_ADD) begin
        period_of[s]   = period;
        deadline_of[s] = aligned_deadline(now, period);
        armed[s]       = 1'b1;
        a.fired        = 1'b1;
        a.deadline     = deadline_of[s];
      end else if (armed[s]) begin
        d     = deadline_of[s];
        prior = d - apdt_pkg::TIME_W'(period_of[s]);
        // fires when past due, or when the previous deadline lies ahead
        if (now >= apdt_pkg::YEAR_2018_START && (d <= now || prior > now)) begin
          d              = aligned_deadline(now, period_of[s]);
          deadline_of[s] = d;
          a.fired        = 1'b1;
        end
        a.deadline = d;
      end
      pending_answers.push_back(a);
    endfunction

    function void check_answer(logic fired, logic [apdt_pkg::TIME_W-1:0] deadline);
      answer_t a;
      if (pending_answers.size() == 0) begin
        if (errors < REPORT_MAX)
          $display("%0t: unexpected result beat due=%0b next_deadline=%0d",
                   $time, fired, deadline);
        errors++;
        return;
      end
      a = pending_answers.pop_front();
      if (fired !== a.fired) begin
        if (errors < REPORT_MAX)
          $display("%0t: due mismatch expected %0b actual %0b", $time, a.fired, fired);
        errors++;
      end
      if (deadline !== a.deadline) begin
        if (errors < REPORT_MAX)
          $display("%0t: next_deadline mismatch expected %0d actual %0d",
                   $time, a.deadline, deadline);
        errors++;
      end
    endfunction
  endclass

  logic                             clk;
  logic                             rst            = 1'b1;
  logic                             cfg_write      = 1'b0;
  logic [apdt_pkg::CFG_INDEX_W-1:0] cfg_index      = '0;
  logic [apdt_pkg::CFG_DATA_W-1:0]  cfg_data       = '0;
  logic                             in_valid       = 1'b0;
  logic                             in_stall;
  logic                             opcode         = apdt_pkg::OP_ADD;
  logic [apdt_pkg::SLOT_W-1:0]      slot           = '0;
  logic [apdt_pkg::PERIOD_W-1:0]    period_seconds = '0;
  logic [apdt_pkg::TIME_W-1:0]      now_seconds    = '0;
  logic                             out_valid;
  logic                             out_stall      = 1'b0;
  logic                             due;
  logic [apdt_pkg::TIME_W-1:0]      next_deadline;

  due_table_tracker tracker;
  int               sent        = 0;
  int               cycle_count = 0;
  logic [apdt_pkg::TIME_W-1:0] clock_base = apdt_pkg::YEAR_2018_START + 32'd1000;

  aligned_periodic_due_table_top u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .slot           (slot),
    .period_seconds (period_seconds),
    .now_seconds    (now_seconds),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .due            (due),
    .next_deadline  (next_deadline)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offer one request beat after a random gap; valid stays up on return
  task automatic send_item(logic op, logic [apdt_pkg::SLOT_W-1:0] s,
                           logic [apdt_pkg::PERIOD_W-1:0] p,
                           logic [apdt_pkg::TIME_W-1:0] t);
    int gap;
    gap = ((sent / 50) % 4 == 3) ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    opcode         <= op;
    slot           <= s;
    period_seconds <= p;
    now_seconds    <= t;
    do @(posedge clk); while (in_stall);
    tracker.note_request(op, s, p, t);
    sent++;
  endtask

  // Register write once every answer is back
  task automatic set_register(logic [apdt_pkg::CFG_INDEX_W-1:0] index,
                              logic [apdt_pkg::CFG_DATA_W-1:0] data);
    while (tracker.pending_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    tracker.write_register(index, data);
    cfg_write <= 1'b0;
  endtask

  // Mostly times near a moving clock and near slot deadlines, some noise
  task automatic random_request();
    logic                          op;
    logic [apdt_pkg::SLOT_W-1:0]   s;
    logic [apdt_pkg::PERIOD_W-1:0] p;
    logic [apdt_pkg::TIME_W-1:0]   t;
    int                            pick;
    op   = ($urandom_range(0, 99) < 25) ? apdt_pkg::OP_ADD : apdt_pkg::OP_CHECK;
    s    = apdt_pkg::SLOT_W'($urandom_range(0, SLOTS - 1));
    pick = $urandom_range(0, 99);
    if (pick < 55)      p = apdt_pkg::PERIOD_W'($urandom_range(1, 120));
    else if (pick < 80) p = apdt_pkg::PERIOD_W'($urandom_range(121, 86400));
    else if (pick < 95) p = apdt_pkg::PERIOD_W'($urandom_range(0, 131071));
    else                p = ($urandom_range(0, 1) != 0) ? '1 : '0;
    clock_base = clock_base + $urandom_range(0, 40);
    if ($urandom_range(0, 99) == 0)
      clock_base = $urandom_range(apdt_pkg::YEAR_2018_START, 32'hFFFF_0000);
    pick = $urandom_range(0, 99);
    if (pick < 50)
      t = clock_base + $urandom_range(0, 200);
    else if (pick < 70 && tracker.armed[s])
      t = tracker.deadline_of[s] + $urandom_range(0, 4) - 2;
    else if (pick < 78 && tracker.armed[s])
      t = tracker.deadline_of[s] - tracker.period_of[s] + $urandom_range(0, 2) - 1;
    else if (pick < 86)
      t = $urandom_range(0, apdt_pkg::YEAR_2018_START - 1);
    else if (pick < 94)
      t = $urandom;
    else begin
      case ($urandom_range(0, 3))
        0:       t = '0;
        1:       t = '1;
        2:       t = apdt_pkg::YEAR_2018_START - 1;
        default: t = apdt_pkg::YEAR_2018_START;
      endcase
    end
    send_item(op, s, p, t);
  endtask

  task automatic random_items(int count);
    repeat (count) random_request();
    in_valid <= 1'b0;
  endtask

  // Receiver: random stalls, one long hold to back the block up
  initial begin
    int hold;
    int results;
    results = 0;
    do @(posedge clk); while (rst);
    forever begin
      hold = ((results / 80) % 3 == 2) ? 0 : $urandom_range(0, 9);
      if (results == 400) hold = 600;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      tracker.check_answer(due, next_deadline);
      results++;
    end
  end

  initial begin
    tracker = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // UTC: unset slots, field extremes, 2018 cutoff, both due conditions
    send_item(apdt_pkg::OP_CHECK, 4'd0, 17'd5, apdt_pkg::YEAR_2018_START);
    send_item(apdt_pkg::OP_CHECK, 4'd15, '1, '1);
    send_item(apdt_pkg::OP_ADD, 4'd0, 17'd1, '0);
    send_item(apdt_pkg::OP_ADD, 4'd15, '1, '1);
    send_item(apdt_pkg::OP_ADD, 4'd1, '0, 32'd1600000000);
    send_item(apdt_pkg::OP_ADD, 4'd2, 17'd86400, 32'hF000_0000);
    send_item(apdt_pkg::OP_ADD, 4'd3, 17'd3600, 32'd1600000000);
    send_item(apdt_pkg::OP_CHECK, 4'd1, '0, 32'd1000);
    send_item(apdt_pkg::OP_CHECK, 4'd0, '0, apdt_pkg::YEAR_2018_START);
    send_item(apdt_pkg::OP_CHECK, 4'd0, '0, apdt_pkg::YEAR_2018_START);
    send_item(apdt_pkg::OP_CHECK, 4'd0, '0, apdt_pkg::YEAR_2018_START + 32'd1);
    send_item(apdt_pkg::OP_CHECK, 4'd2, '0, apdt_pkg::YEAR_2018_START);
    send_item(apdt_pkg::OP_CHECK, 4'd3, '0, 32'd1600000000);
    send_item(apdt_pkg::OP_CHECK, 4'd3, '0, 32'd1600002000);
    send_item(apdt_pkg::OP_CHECK, 4'd15, '0, '1);
    send_item(apdt_pkg::OP_CHECK, 4'd1, '0, 32'd1600000000);
    send_item(apdt_pkg::OP_CHECK, 4'd1, '0, apdt_pkg::YEAR_2018_START - 32'd1);
    send_item(apdt_pkg::OP_ADD, 4'd7, 17'h10000, 32'h1234_5678);
    send_item(apdt_pkg::OP_CHECK, 4'd7, '0, 32'h2000_0000);
    random_items(220);

    // Local time, most negative zone: offset time below zero, wrap past 2^32
    set_register(apdt_pkg::CFG_ZONE_OFFSET, apdt_pkg::CFG_DATA_W'(-50400));
    set_register(apdt_pkg::CFG_LOCAL_TIME_ENABLE, apdt_pkg::CFG_DATA_W'(1));
    send_item(apdt_pkg::OP_ADD, 4'd4, 17'd7, 32'd5);
    send_item(apdt_pkg::OP_ADD, 4'd5, '0, '0);
    send_item(apdt_pkg::OP_CHECK, 4'd5, '0, apdt_pkg::YEAR_2018_START);
    send_item(apdt_pkg::OP_ADD, 4'd6, 17'd86400, '1);
    send_item(apdt_pkg::OP_ADD, 4'd8, '1, '0);
    send_item(apdt_pkg::OP_CHECK, 4'd4, '0, apdt_pkg::YEAR_2018_START);
    random_items(220);

    set_register(apdt_pkg::CFG_ZONE_OFFSET, apdt_pkg::CFG_DATA_W'(50400));
    random_items(220);

    // Full-width offsets
    set_register(apdt_pkg::CFG_ZONE_OFFSET, 17'h10000);
    random_items(180);
    set_register(apdt_pkg::CFG_ZONE_OFFSET, 17'h0FFFF);
    random_items(180);

    // Offset present but local time off
    set_register(apdt_pkg::CFG_LOCAL_TIME_ENABLE, apdt_pkg::CFG_DATA_W'(0));
    set_register(apdt_pkg::CFG_ZONE_OFFSET,
                 apdt_pkg::CFG_DATA_W'(int'($urandom_range(0, 100800)) - 50400));
    random_items(200);

    set_register(apdt_pkg::CFG_LOCAL_TIME_ENABLE, apdt_pkg::CFG_DATA_W'(1));
    random_items(200);

    set_register(apdt_pkg::CFG_ZONE_OFFSET, '0);
    random_items(180);

    // Drain and let the pipe settle
    while (tracker.pending_answers.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (tracker.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
